### rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and codes for the string key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    // Bits of a character position within one 32-byte slot
    localparam int SLOT_BITS = 5;
    localparam int LEN_W     = 5;

    // Input kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_CODE   = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_DUP      = 3'd2;
    localparam logic [2:0] STAT_FOUND    = 3'd3;
    localparam logic [2:0] STAT_MISSING  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LREQ,
        ST_LCMP,
        ST_NREQ,
        ST_NCMP,
        ST_VREQ,
        ST_VOUT,
        ST_EMIT
    } skvt_state_t;

endpackage

### rtl/core/skvt_ram.sv
// ----------------------------------------------------------------------------
// skvt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/string_key_value_table_core.sv
// ----------------------------------------------------------------------------
// string_key_value_table_core
// Name/code table filled in order, searched linearly by exact name match.
// ----------------------------------------------------------------------------
// An end of code or search walks the stored entries through the length RAM
// and name RAM: ST_LREQ and ST_LCMP per entry, ST_NREQ and ST_NCMP per compared
// character, then ST_EMIT gives the result; a found code streams through ST_VREQ
// and ST_VOUT per character. Other transfers cause no walk. Input is held off
// during the walk and stream. Reset (async, active low)
// empties the table; the RAM contents stay undefined until written.
module string_key_value_table_core #(
    parameter int ENTRIES    = 128,
    parameter int NAME_CHARS = 25,
    parameter int CODE_CHARS = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  logic [2:0]  s_axis_tuser,   // kind[1:0], has_char[2]
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[2:0], code_char[10:3], zero[15:11]
    output logic        m_axis_tuser,   // char_valid
    output logic        m_axis_tlast    // final_res
);

    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int SB  = skvt_pkg::SLOT_BITS;
    localparam int LW  = skvt_pkg::LEN_W;
    localparam int SLOT_DEPTH = ENTRIES * (2 ** SB);
    localparam logic [LW-1:0] NAME_MAX = LW'(NAME_CHARS);
    localparam logic [LW-1:0] CODE_MAX = LW'(CODE_CHARS);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    skvt_pkg::skvt_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] nlen_reg, nlen_next;
    logic          nclosed_reg, nclosed_next;
    logic [LW-1:0] clen_reg, clen_next;
    logic [LW-1:0] klen_reg, klen_next;
    logic          kclosed_reg, kclosed_next;
    logic          search_reg, search_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] vlen_reg, vlen_next;
    logic [2:0]    stat_reg, stat_next;
    logic          ovalid_reg, ovalid_next;
    logic [2:0]    ostat_reg, ostat_next;
    logic [7:0]    ochar_reg, ochar_next;
    logic          ocv_reg, ocv_next;
    logic          olast_reg, olast_next;

    logic [7:0] stage_buf [2 ** LW];
    logic [7:0] key_buf   [2 ** LW];

    logic       accept, out_free, room, has_char, eos;
    logic [1:0] kind;
    logic [LW-1:0] name_pos, key_pos, cmp_len;
    logic       name_we, code_we, key_we, len_we;
    logic [7:0] name_rdata, code_rdata, key_char;
    logic [2*LW-1:0] len_rdata;
    logic       len_hit, char_hit, last_entry;

    assign kind     = s_axis_tuser[1:0];
    assign has_char = s_axis_tuser[2];
    assign eos      = s_axis_tlast;
    assign s_axis_tready = (state_reg == skvt_pkg::ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;
    assign room     = (count_reg < FULL_CNT);

    // A closed string restarts at position zero on its next character
    assign name_pos = nclosed_reg ? '0 : nlen_reg;
    assign key_pos  = kclosed_reg ? '0 : klen_reg;

    assign name_we = accept && (kind == skvt_pkg::KIND_NAME) && has_char
                     && (name_pos < NAME_MAX) && room;
    assign code_we = accept && (kind == skvt_pkg::KIND_CODE) && has_char
                     && (clen_reg < CODE_MAX) && room;
    assign key_we  = accept && (kind == skvt_pkg::KIND_SEARCH) && has_char
                     && (key_pos < NAME_MAX);
    assign len_we  = (state_reg == skvt_pkg::ST_EMIT) && out_free && !search_reg
                     && (stat_reg == skvt_pkg::STAT_INSERTED);

    skvt_ram #(.WIDTH(8), .DEPTH(SLOT_DEPTH)) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr ({count_reg[IW-1:0], name_pos}),
        .wdata (s_axis_tdata),
        .raddr ({idx_reg[IW-1:0], pos_reg}),
        .rdata (name_rdata)
    );

    skvt_ram #(.WIDTH(8), .DEPTH(SLOT_DEPTH)) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr ({count_reg[IW-1:0], clen_reg}),
        .wdata (s_axis_tdata),
        .raddr ({idx_reg[IW-1:0], pos_reg}),
        .rdata (code_rdata)
    );

    // Name length in the upper half, code length in the lower
    skvt_ram #(.WIDTH(2 * LW), .DEPTH(ENTRIES)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({nlen_reg, clen_reg}),
        .raddr (idx_reg[IW-1:0]),
        .rdata (len_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            stage_buf[name_pos] <= s_axis_tdata;
        end
        if (key_we)
        begin
            key_buf[key_pos] <= s_axis_tdata;
        end
    end

    assign cmp_len    = search_reg ? klen_reg : nlen_reg;
    assign key_char   = search_reg ? key_buf[pos_reg] : stage_buf[pos_reg];
    assign len_hit    = (len_rdata[2*LW-1:LW] == cmp_len);
    assign char_hit   = (name_rdata == key_char);
    assign last_entry = ((idx_reg + CW'(1)) == count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                if (accept && eos && (kind == skvt_pkg::KIND_CODE))
                begin
                    state_next = (room && (count_reg != '0)) ? skvt_pkg::ST_LREQ
                                                             : skvt_pkg::ST_EMIT;
                end
                else if (accept && eos && (kind == skvt_pkg::KIND_SEARCH))
                begin
                    state_next = (count_reg != '0) ? skvt_pkg::ST_LREQ
                                                   : skvt_pkg::ST_EMIT;
                end
            end
            skvt_pkg::ST_LREQ: state_next = skvt_pkg::ST_LCMP;
            skvt_pkg::ST_LCMP:
            begin
                if (len_hit && (cmp_len == '0))
                begin
                    state_next = (search_reg && (len_rdata[LW-1:0] != '0))
                                 ? skvt_pkg::ST_VREQ : skvt_pkg::ST_EMIT;
                end
                else if (len_hit)
                begin
                    state_next = skvt_pkg::ST_NREQ;
                end
                else
                begin
                    state_next = last_entry ? skvt_pkg::ST_EMIT : skvt_pkg::ST_LREQ;
                end
            end
            skvt_pkg::ST_NREQ: state_next = skvt_pkg::ST_NCMP;
            skvt_pkg::ST_NCMP:
            begin
                if (!char_hit)
                begin
                    state_next = last_entry ? skvt_pkg::ST_EMIT : skvt_pkg::ST_LREQ;
                end
                else if ((pos_reg + LW'(1)) == cmp_len)
                begin
                    state_next = (search_reg && (vlen_reg != '0))
                                 ? skvt_pkg::ST_VREQ : skvt_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = skvt_pkg::ST_NREQ;
                end
            end
            skvt_pkg::ST_VREQ: state_next = skvt_pkg::ST_VOUT;
            skvt_pkg::ST_VOUT:
            begin
                if (out_free)
                begin
                    state_next = ((pos_reg + LW'(1)) == vlen_reg) ? skvt_pkg::ST_IDLE
                                                                 : skvt_pkg::ST_VREQ;
                end
            end
            skvt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            default: state_next = skvt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next   = count_reg;
        nlen_next    = nlen_reg;
        nclosed_next = nclosed_reg;
        clen_next    = clen_reg;
        klen_next    = klen_reg;
        kclosed_next = kclosed_reg;
        search_next  = search_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        vlen_next    = vlen_reg;
        stat_next    = stat_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        ostat_next   = ostat_reg;
        ochar_next   = ochar_reg;
        ocv_next     = ocv_reg;
        olast_next   = olast_reg;
        unique case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                idx_next = '0;
                pos_next = '0;
                if (accept)
                begin
                    case (kind)
                        skvt_pkg::KIND_NAME:
                        begin
                            nlen_next    = name_pos + LW'(has_char && (name_pos < NAME_MAX));
                            nclosed_next = eos;
                        end
                        skvt_pkg::KIND_CODE:
                        begin
                            clen_next   = clen_reg + LW'(has_char && (clen_reg < CODE_MAX));
                            search_next = 1'b0;
                            stat_next   = room ? skvt_pkg::STAT_INSERTED
                                               : skvt_pkg::STAT_FULL;
                        end
                        skvt_pkg::KIND_SEARCH:
                        begin
                            klen_next    = key_pos + LW'(has_char && (key_pos < NAME_MAX));
                            kclosed_next = eos;
                            search_next  = 1'b1;
                            stat_next    = skvt_pkg::STAT_MISSING;
                        end
                        default: ;
                    endcase
                end
            end
            skvt_pkg::ST_LREQ: ;
            skvt_pkg::ST_LCMP:
            begin
                vlen_next = len_rdata[LW-1:0];
                pos_next  = '0;
                if (len_hit && (cmp_len == '0))
                begin
                    stat_next = search_reg ? skvt_pkg::STAT_FOUND : skvt_pkg::STAT_DUP;
                end
                else if (!len_hit)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            skvt_pkg::ST_NREQ: ;
            skvt_pkg::ST_NCMP:
            begin
                if (!char_hit)
                begin
                    idx_next = idx_reg + CW'(1);
                    pos_next = '0;
                end
                else if ((pos_reg + LW'(1)) == cmp_len)
                begin
                    stat_next = search_reg ? skvt_pkg::STAT_FOUND : skvt_pkg::STAT_DUP;
                    pos_next  = '0;
                end
                else
                begin
                    pos_next = pos_reg + LW'(1);
                end
            end
            skvt_pkg::ST_VREQ: ;
            skvt_pkg::ST_VOUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = skvt_pkg::STAT_FOUND;
                    ochar_next  = code_rdata;
                    ocv_next    = 1'b1;
                    olast_next  = ((pos_reg + LW'(1)) == vlen_reg);
                    pos_next    = pos_reg + LW'(1);
                end
            end
            skvt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = stat_reg;
                    ochar_next  = '0;
                    ocv_next    = 1'b0;
                    olast_next  = 1'b1;
                    if (!search_reg)
                    begin
                        // Drop the staged pair once the outcome is out
                        if (stat_reg == skvt_pkg::STAT_INSERTED)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        nlen_next    = '0;
                        nclosed_next = 1'b0;
                        clen_next    = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= skvt_pkg::ST_IDLE;
            count_reg   <= '0;
            nlen_reg    <= '0;
            nclosed_reg <= 1'b0;
            clen_reg    <= '0;
            klen_reg    <= '0;
            kclosed_reg <= 1'b0;
            search_reg  <= 1'b0;
            idx_reg     <= '0;
            pos_reg     <= '0;
            stat_reg    <= skvt_pkg::STAT_INSERTED;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            nlen_reg    <= nlen_next;
            nclosed_reg <= nclosed_next;
            clen_reg    <= clen_next;
            klen_reg    <= klen_next;
            kclosed_reg <= kclosed_next;
            search_reg  <= search_next;
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            stat_reg    <= stat_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vlen_reg  <= vlen_next;
        ostat_reg <= ostat_next;
        ochar_reg <= ochar_next;
        ocv_reg   <= ocv_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {5'd0, ochar_reg, ostat_reg};
    assign m_axis_tuser  = ocv_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

### bench/tb_string_key_value_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_key_value_table_core
// Self-checking bench for the string key/value table.
// Drives character streams for inserts and searches. A behavioural copy of
// the table predicts every outcome and every code character streamed back.
// The run covers directed corner cases, random traffic under three idling
// patterns, a long output stall, and finally fills the table and overflows it.
// ----------------------------------------------------------------------------
module tb_string_key_value_table_core;

    localparam int ENTRIES    = 128;
    localparam int NAME_CHARS = 25;
    localparam int CODE_CHARS = 30;
    localparam int SLOT       = 32;
    localparam int CYCLE_CAP  = 4000000;
    localparam int POOL_SZ    = 64;
    localparam int RAND_ITEMS = 36;

    // Kind value with no meaning to the block
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] code_char;
        logic       char_valid;
        logic       final_res;
    } table_result_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       has_char;
        logic       eos;
        logic       typed;
        logic [2:0] typed_status;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    string_key_value_table_core #(
        .ENTRIES   (ENTRIES),
        .NAME_CHARS(NAME_CHARS),
        .CODE_CHARS(CODE_CHARS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Table copy used for prediction
    logic [7:0] tbl_names [ENTRIES][SLOT];
    logic [7:0] tbl_codes [ENTRIES][SLOT];
    int         tbl_name_len [ENTRIES];
    int         tbl_code_len [ENTRIES];
    int         tbl_count;
    logic [7:0] search_key [SLOT];
    int         search_len;
    logic       search_done;
    int         pend_name_len;
    logic       pend_name_done;
    int         pend_code_len;

    table_result_t pending_results [$];

    // Recently used names, so that searches and duplicates hit
    logic [7:0] name_pool [POOL_SZ][SLOT];
    int         name_pool_len [POOL_SZ];
    int         name_pool_n;

    int errors;
    int cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    logic hold_tog;
    logic hold_seen;
    int n_results;
    int n_status [5];
    int n_items;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, want, got, $time);
        errors++;
    endtask

    function automatic logic name_matches(input int e, input logic [7:0] s [SLOT],
                                          input int len);
        if (tbl_name_len[e] != len)
            return 1'b0;
        for (int k = 0; k < len; k++)
            if (tbl_names[e][k] != s[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the table copy by one accepted transfer and queue its results
    task automatic predict_table(input logic [1:0] kind, input logic [7:0] ch,
                                 input logic has, input logic eos,
                                 input logic typed, input logic [2:0] typed_status);
        table_result_t r;
        logic [7:0] staged [SLOT];
        logic room;
        logic [2:0] outcome;
        int hit;
        room = tbl_count < ENTRIES;
        r = '0;
        r.final_res = 1'b1;
        case (kind)
            skvt_pkg::KIND_NAME:
            begin
                if (pend_name_done)
                begin
                    pend_name_len = 0;
                    pend_name_done = 1'b0;
                end
                if (has && pend_name_len < NAME_CHARS)
                begin
                    if (room)
                        tbl_names[tbl_count][pend_name_len] = ch;
                    pend_name_len++;
                end
                if (eos)
                    pend_name_done = 1'b1;
            end
            skvt_pkg::KIND_CODE:
            begin
                if (has && pend_code_len < CODE_CHARS)
                begin
                    if (room)
                        tbl_codes[tbl_count][pend_code_len] = ch;
                    pend_code_len++;
                end
                if (eos)
                begin
                    if (!room)
                    begin
                        outcome = skvt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        outcome = skvt_pkg::STAT_INSERTED;
                        staged = tbl_names[tbl_count];
                        for (int e = 0; e < tbl_count; e++)
                            if (name_matches(e, staged, pend_name_len))
                                outcome = skvt_pkg::STAT_DUP;
                        if (outcome == skvt_pkg::STAT_INSERTED)
                        begin
                            tbl_name_len[tbl_count] = pend_name_len;
                            tbl_code_len[tbl_count] = pend_code_len;
                            tbl_count++;
                        end
                    end
                    pend_name_len = 0;
                    pend_name_done = 1'b0;
                    pend_code_len = 0;
                    r.status = typed ? typed_status : outcome;
                    pending_results.push_back(r);
                end
            end
            skvt_pkg::KIND_SEARCH:
            begin
                if (search_done)
                begin
                    search_len = 0;
                    search_done = 1'b0;
                end
                if (has && search_len < NAME_CHARS)
                begin
                    search_key[search_len] = ch;
                    search_len++;
                end
                if (eos)
                begin
                    search_done = 1'b1;
                    hit = -1;
                    for (int e = 0; e < tbl_count && hit < 0; e++)
                        if (name_matches(e, search_key, search_len))
                            hit = e;
                    if (hit < 0)
                    begin
                        r.status = skvt_pkg::STAT_MISSING;
                    end
                    else if (tbl_code_len[hit] == 0)
                    begin
                        r.status = skvt_pkg::STAT_FOUND;
                    end
                    else
                    begin
                        for (int k = 0; k < tbl_code_len[hit]; k++)
                        begin
                            r.status = skvt_pkg::STAT_FOUND;
                            r.code_char = tbl_codes[hit][k];
                            r.char_valid = 1'b1;
                            r.final_res = (k + 1 == tbl_code_len[hit]);
                            if (k + 1 < tbl_code_len[hit])
                                pending_results.push_back(r);
                        end
                    end
                    if (typed)
                        r.status = typed_status;
                    pending_results.push_back(r);
                end
            end
            default: ;  // unknown kind: ignored
        endcase
    endtask

    // Offer one transfer, with random idle gaps in front
    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic has, input logic eos,
                             input logic typed = 1'b0, input logic [2:0] typed_status = '0);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= {has, kind};
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_table(kind, ch, has, eos, typed, typed_status);
        n_items++;
        @(negedge clk);
    endtask

    // Send a string, salted now and then with character-less transfers
    task automatic send_string(input logic [1:0] kind, input logic [7:0] s [SLOT],
                               input int len);
        logic split_end;
        split_end = ($urandom_range(9) == 0);
        if (len == 0)
        begin
            send_item(kind, 8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(9) == 0)
                send_item(kind, 8'($urandom), 1'b0, 1'b0);
            send_item(kind, s[k], 1'b1, (k == len - 1) && !split_end);
        end
        if (split_end)
            send_item(kind, 8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic make_string(output logic [7:0] s [SLOT], output int len, input int max_len);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            len = $urandom_range(max_len + 3, 20);
        else
            len = $urandom_range(4);
        if (len > SLOT)
            len = SLOT;
        for (int k = 0; k < SLOT; k++)
            s[k] = (pick % 2) ? 8'($urandom) : 8'(8'h41 + $urandom_range(2));
    endtask

    task automatic random_name(output logic [7:0] s [SLOT], output int len);
        int p;
        if (name_pool_n > 0 && $urandom_range(99) < 45)
        begin
            p = $urandom_range(name_pool_n - 1);
            s = name_pool[p];
            len = name_pool_len[p];
        end
        else
        begin
            make_string(s, len, NAME_CHARS);
            if (name_pool_n < POOL_SZ)
            begin
                p = name_pool_n;
                name_pool_n = name_pool_n + 1;
            end
            else
            begin
                p = $urandom_range(POOL_SZ - 1);
            end
            name_pool[p] = s;
            name_pool_len[p] = len;
        end
    endtask

    task automatic random_traffic(input int count);
        logic [7:0] s [SLOT];
        int len;
        int pick;
        int start;
        start = n_items;
        while (n_items - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                random_name(s, len);
                if ($urandom_range(9) != 0)
                    send_string(skvt_pkg::KIND_NAME, s, len);
                make_string(s, len, CODE_CHARS);
                send_string(skvt_pkg::KIND_CODE, s, len);
            end
            else if (pick < 85)
            begin
                random_name(s, len);
                send_string(skvt_pkg::KIND_SEARCH, s, len);
            end
            else if (pick < 92)
            begin
                send_item(KIND_UNUSED, 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            else
            begin
                // open name that the next code will close
                random_name(s, len);
                for (int k = 0; k < len && k < 3; k++)
                    send_item(skvt_pkg::KIND_NAME, s[k], 1'b1, 1'b0);
            end
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen <= hold_tog;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("MISMATCH unexpected result status %0d (t=%0t)",
                         m_axis_tdata[2:0], $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status <= skvt_pkg::STAT_MISSING)
                    n_status[want.status]++;
                if (m_axis_tdata[2:0] !== want.status)
                    report_mismatch("status", want.status, m_axis_tdata[2:0]);
                if (m_axis_tdata[10:3] !== want.code_char)
                    report_mismatch("code_char", want.code_char, m_axis_tdata[10:3]);
                if (m_axis_tdata[15:11] !== 5'd0)
                    report_mismatch("tdata pad", 0, m_axis_tdata[15:11]);
                if (m_axis_tuser !== want.char_valid)
                    report_mismatch("char_valid", want.char_valid, m_axis_tuser);
                if (m_axis_tlast !== want.final_res)
                    report_mismatch("final_res", want.final_res, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    stim_row_t directed [] = '{
        '{skvt_pkg::KIND_SEARCH, 8'h00, 1'b0, 1'b1, 1'b1, skvt_pkg::STAT_MISSING}, // empty table
        '{skvt_pkg::KIND_CODE,   8'h00, 1'b0, 1'b1, 1'b1, skvt_pkg::STAT_INSERTED}, // no name
        '{skvt_pkg::KIND_SEARCH, 8'h00, 1'b0, 1'b1, 1'b1, skvt_pkg::STAT_FOUND},  // empty code
        '{skvt_pkg::KIND_CODE,   8'h00, 1'b0, 1'b1, 1'b1, skvt_pkg::STAT_DUP},    // empty name
        '{skvt_pkg::KIND_NAME,   8'h00, 1'b1, 1'b1, 1'b0, 3'd0},
        '{skvt_pkg::KIND_CODE,   8'hFF, 1'b1, 1'b0, 1'b0, 3'd0},
        '{skvt_pkg::KIND_CODE,   8'h00, 1'b0, 1'b0, 1'b0, 3'd0},
        '{skvt_pkg::KIND_CODE,   8'h80, 1'b1, 1'b1, 1'b1, skvt_pkg::STAT_INSERTED},
        '{skvt_pkg::KIND_SEARCH, 8'h00, 1'b1, 1'b1, 1'b0, 3'd0},
        '{skvt_pkg::KIND_NAME,   8'h00, 1'b1, 1'b1, 1'b0, 3'd0},
        '{skvt_pkg::KIND_CODE,   8'h55, 1'b1, 1'b1, 1'b1, skvt_pkg::STAT_DUP},
        '{skvt_pkg::KIND_NAME,   8'hFF, 1'b1, 1'b0, 1'b0, 3'd0},           // name left open
        '{skvt_pkg::KIND_NAME,   8'h7F, 1'b0, 1'b0, 1'b0, 3'd0},
        '{skvt_pkg::KIND_CODE,   8'hAA, 1'b1, 1'b1, 1'b1, skvt_pkg::STAT_INSERTED},
        '{KIND_UNUSED,           8'hFF, 1'b1, 1'b1, 1'b0, 3'd0},           // unknown kind
        '{skvt_pkg::KIND_SEARCH, 8'hFF, 1'b1, 1'b0, 1'b0, 3'd0},
        '{skvt_pkg::KIND_SEARCH, 8'h12, 1'b0, 1'b1, 1'b0, 3'd0},
        '{skvt_pkg::KIND_SEARCH, 8'hFF, 1'b1, 1'b0, 1'b0, 3'd0},
        '{skvt_pkg::KIND_SEARCH, 8'h01, 1'b1, 1'b1, 1'b1, skvt_pkg::STAT_MISSING},
        '{skvt_pkg::KIND_NAME,   8'h00, 1'b0, 1'b1, 1'b0, 3'd0},           // empty name closed
        '{skvt_pkg::KIND_CODE,   8'h33, 1'b1, 1'b1, 1'b1, skvt_pkg::STAT_DUP}
    };

    initial
    begin
        logic [7:0] s [SLOT];
        int len;
        int idx;
        errors = 0;
        cycles = 0;
        n_results = 0;
        n_items = 0;
        n_status = '{default: 0};
        tbl_count = 0;
        search_len = 0;
        search_done = 1'b0;
        pend_name_len = 0;
        pend_name_done = 1'b0;
        pend_code_len = 0;
        name_pool_n = 0;
        hold_left = 0;
        hold_tog = 1'b0;
        hold_seen = 1'b0;
        tx_idle_pct = 25;
        rx_idle_pct = 85;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i].kind, directed[i].ch, directed[i].has_char,
                      directed[i].eos, directed[i].typed, directed[i].typed_status);

        random_traffic(RAND_ITEMS);
        tx_idle_pct = 85;
        rx_idle_pct = 25;
        random_traffic(RAND_ITEMS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(RAND_ITEMS);

        // Long output stall while searches keep coming
        drain();
        hold_tog <= ~hold_tog;
        for (int k = 0; k < 6; k++)
        begin
            random_name(s, len);
            send_string(skvt_pkg::KIND_SEARCH, s, len);
        end

        // Fill the table with unique short names, then overflow it
        drain();
        idx = 0;
        while (tbl_count < ENTRIES)
        begin
            if (idx < 256)
            begin
                send_item(skvt_pkg::KIND_NAME, idx[7:0], 1'b1, 1'b1);
            end
            else
            begin
                send_item(skvt_pkg::KIND_NAME, idx[7:0], 1'b1, 1'b0);
                send_item(skvt_pkg::KIND_NAME, 8'hF0 | 8'(idx[11:8]), 1'b1, 1'b1);
            end
            send_item(skvt_pkg::KIND_CODE, 8'($urandom), 1'b1, 1'b1);
            idx++;
        end
        for (int k = 0; k < 3; k++)
        begin
            random_name(s, len);
            send_string(skvt_pkg::KIND_NAME, s, len);
            make_string(s, len, CODE_CHARS);
            send_string(skvt_pkg::KIND_CODE, s, len);
        end
        send_item(skvt_pkg::KIND_SEARCH, 8'h05, 1'b1, 1'b0);
        send_item(skvt_pkg::KIND_SEARCH, 8'hF0, 1'b1, 1'b1);
        send_item(skvt_pkg::KIND_SEARCH, 8'hEE, 1'b1, 1'b1);

        drain();
        $display("Covered %0d transfers, %0d results, table filled to %0d entries",
                 n_items, n_results, tbl_count);
        $display("Outcomes: inserted %0d, full %0d, duplicate %0d, found %0d, missing %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/core/skvt_pkg.sv
rtl/core/skvt_ram.sv
rtl/core/string_key_value_table_core.sv
bench/tb_string_key_value_table_core.sv
